### sv/scpa_pkg.sv
// Shared types, codes and reset constants of the size-class pool allocator.
package scpa_pkg;

  localparam int NCLS_MAX    = 4;
  localparam int SIZE_W      = 16;
  localparam int COUNT_W     = 11;
  localparam int CLS_W       = 2;
  localparam int FADDR_W     = 20;
  localparam int CFG_IDX_W   = 4;
  localparam int CAP_W       = 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_FIRST  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_FIRST = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LAST  = 4'd7;

  localparam logic [NCLS_MAX-1:0][SIZE_W-1:0] RST_SIZE =
    {16'd0, 16'd128, 16'd64, 16'd32};
  localparam logic [NCLS_MAX-1:0][COUNT_W-1:0] RST_COUNT =
    {11'd0, 11'd25, 11'd50, 11'd100};

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNSUP = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_MUL,
    BS_ADD
  } base_state_t;

  typedef enum logic {
    BK_ISSUE,
    BK_RESULT
  } bk_state_t;

  typedef logic [NCLS_MAX-1:0][SIZE_W-1:0] size_vec_t;

  // Classified request as it waits between front and back.
  typedef struct packed {
    op_t                op;
    logic               found;
    logic [CLS_W-1:0]   cls;
    logic [FADDR_W-1:0] free_addr;
  } req_t;

  // Count register write: refills one class.
  typedef struct packed {
    logic               valid;
    logic [CLS_W-1:0]   cls;
    logic [COUNT_W-1:0] count;
  } refill_t;

  function automatic logic [CAP_W-1:0] cap_count(input logic [COUNT_W-1:0] v,
                                                  input logic [CAP_W-1:0] maxb);
    logic [CAP_W-1:0] ext;
    ext = {{(CAP_W-COUNT_W){1'b0}}, v};
    return (ext > maxb) ? maxb : ext;
  endfunction

endpackage

### sv/size_class_pool_allocator_unit.sv
// Top level of the size-class pool allocator.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------
//  s_*     | in  | s_tvalid / s_tready | request: op, size, address to free
//  m_*     | out | m_tvalid / m_tready | result: ok, address, class, status
//  cfg_*   | in  | cfg_valid/cfg_ready | register index and write data
//
// Back end: a request takes an issue step, which updates the class counters and touches
// the free stack memory, then a result step, which forms the address into the result
// register once it is free; no request issues until the last result is loaded.
// Reset and each write to a mapped register start a class base pass (a multiply and an
// add per class but the last) during which requests queue but do not execute.
// The two-entry queue lets the input run on until it is full behind a stalled result.
module size_class_pool_allocator_unit #(
  parameter int NUM_CLASSES = 4,
  parameter int MAX_BLOCKS  = 1024,
  parameter int ADDR_BITS   = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,    // [15:0] req_size, [35:16] free_addr, [39:36] zero
  input  logic        s_tuser,    // [0] op: 0 allocate, 1 free
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [19:0] block_addr, [21:20] class_index, [23:22] zero
  output logic [2:0]  m_tuser,    // [0] ok, [2:1] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import scpa_pkg::*;

  size_vec_t                            sizes;
  logic [NCLS_MAX-1:0][ADDR_BITS-1:0]   bases;
  logic                                 base_busy;
  refill_t                              refill;
  logic                                 q_push, q_full, q_pop, q_valid;
  req_t                                 push_entry, head;

  scpa_cfg #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sizes     (sizes),
    .bases     (bases),
    .busy      (base_busy),
    .refill    (refill)
  );

  scpa_front #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .sizes    (sizes),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  scpa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (head)
  );

  scpa_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_BLOCKS  (MAX_BLOCKS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (head),
    .q_pop     (q_pop),
    .base_busy (base_busy),
    .sizes     (sizes),
    .bases     (bases),
    .refill    (refill),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // No request may execute against stale class bases.
  a_no_issue_while_busy: assert property (@(posedge clk) disable iff (rst)
    base_busy |-> !q_pop)
    else $error("request issued during class base pass");

  // ok flag and status code agree.
  a_ok_matches_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] == (m_tuser[2:1] == ST_OK)))
    else $error("ok flag disagrees with status");

  // Failures never carry an address.
  a_fail_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[19:0] == 20'd0))
    else $error("failed transaction returned an address");

  // Unsupported size reports class zero.
  a_unsup_class_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2:1] == ST_UNSUP) |-> (m_tdata[21:20] == 2'd0))
    else $error("unsupported size with nonzero class");

endmodule

### sv/scpa_cfg.sv
// Configuration registers and the sequential class base recomputation.
module scpa_cfg #(
  parameter int MAX_BLOCKS = 1024,
  parameter int ADDR_BITS  = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [scpa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [scpa_pkg::SIZE_W-1:0]           cfg_data,
  output scpa_pkg::size_vec_t                   sizes,
  output logic [scpa_pkg::NCLS_MAX-1:0][ADDR_BITS-1:0] bases,
  output logic                                  busy,
  output scpa_pkg::refill_t                     refill
);
  import scpa_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int PROD_W = SIZE_W + CNT_W;

  logic [NCLS_MAX-1:0][CNT_W-1:0] counts;
  logic [NCLS_MAX-1:1][ADDR_BITS-1:0] upper;
  logic [CLS_W-1:0]               step;
  logic [PROD_W-1:0]              prod;
  base_state_t                    state, state_next;
  logic                           wr, wr_known, mul_en, add_en;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid;
  assign wr_known  = wr && (cfg_index <= CFG_COUNT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NCLS_MAX; c++) begin
        sizes[c]  <= RST_SIZE[c];
        counts[c] <= CNT_W'(cap_count(RST_COUNT[c], CAP_W'(MAX_BLOCKS)));
      end
    end else if (wr_known) begin
      if (cfg_index < CFG_COUNT_FIRST) begin
        sizes[cfg_index[CLS_W-1:0]] <= cfg_data;
      end else begin
        counts[cfg_index[CLS_W-1:0]] <=
          CNT_W'(cap_count(cfg_data[COUNT_W-1:0], CAP_W'(MAX_BLOCKS)));
      end
    end
  end

  always_comb begin
    refill.valid = wr_known && (cfg_index >= CFG_COUNT_FIRST);
    refill.cls   = cfg_index[CLS_W-1:0];
    refill.count = cfg_data[COUNT_W-1:0];
  end

  // Base FSM: one multiply then one add per class but the last, restarted by any mapped write.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_MUL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE: if (wr_known) state_next = BS_MUL;
      BS_MUL: begin
        state_next = wr_known ? BS_MUL : BS_ADD;
      end
      BS_ADD: begin
        if (wr_known) begin
          state_next = BS_MUL;
        end else if (step == CLS_W'(NCLS_MAX - 2)) begin
          state_next = BS_IDLE;
        end else begin
          state_next = BS_MUL;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != BS_IDLE);
    mul_en = (state == BS_MUL) && !wr_known;
    add_en = (state == BS_ADD) && !wr_known;
  end

  always_ff @(posedge clk) begin
    if (rst || wr_known) begin
      step <= '0;
    end else if (add_en) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(sizes[step]) * PROD_W'(counts[step]);
    end
  end

  // class 0 always starts at zero
  assign bases = {upper, {ADDR_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (add_en) begin
      upper[step + 1'b1] <= ADDR_BITS'(bases[step] + ADDR_BITS'(prod));
    end
  end

endmodule

### sv/scpa_front.sv
// Input side: unpacks requests and picks the size class.
module scpa_front #(
  parameter int NUM_CLASSES = 4
) (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,
  input  logic                 s_tuser,
  input  scpa_pkg::size_vec_t  sizes,
  input  logic                 q_full,
  output logic                 q_push,
  output scpa_pkg::req_t       q_entry
);
  import scpa_pkg::*;

  logic [SIZE_W-1:0] req_size;

  assign req_size = s_tdata[15:0];
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // First class in index order whose block size covers the request.
  always_comb begin
    q_entry.op        = op_t'(s_tuser);
    q_entry.free_addr = s_tdata[35:16];
    q_entry.found     = 1'b0;
    q_entry.cls       = '0;
    for (int c = 0; c < NCLS_MAX; c++) begin
      if (c < NUM_CLASSES && !q_entry.found && req_size <= sizes[c]) begin
        q_entry.found = 1'b1;
        q_entry.cls   = CLS_W'(c);
      end
    end
  end

endmodule

### sv/scpa_queue.sv
// Small request FIFO between the classifying front and the executing back.
module scpa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scpa_pkg::req_t push_entry,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output scpa_pkg::req_t head
);
  import scpa_pkg::*;

  req_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0]   fill;
  logic                   do_push, do_pop;

  assign full    = (fill == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign valid   = (fill != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QUEUE_PTR_W+1)'(do_push) - (QUEUE_PTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

### sv/scpa_back.sv
// Execution side: per-class counters, free stack memory and result register.
module scpa_back #(
  parameter int NUM_CLASSES = 4,
  parameter int MAX_BLOCKS  = 1024,
  parameter int ADDR_BITS   = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  scpa_pkg::req_t                        q_entry,
  output logic                                  q_pop,
  input  logic                                  base_busy,
  input  scpa_pkg::size_vec_t                   sizes,
  input  logic [scpa_pkg::NCLS_MAX-1:0][ADDR_BITS-1:0] bases,
  input  scpa_pkg::refill_t                     refill,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [23:0]                           m_tdata,
  output logic [2:0]                            m_tuser
);
  import scpa_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int MEM_AW = CIDX_W + IDX_W;
  localparam int MEM_D  = 1 << MEM_AW;
  localparam int PROD_W = SIZE_W + CNT_W;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_STACK,
    SRC_FRESH
  } src_t;

  logic [NCLS_MAX-1:0][CNT_W-1:0] pushed, fresh;
  logic [ADDR_BITS-1:0]           mem [MEM_D];
  logic [ADDR_BITS-1:0]           rdata;
  logic [PROD_W-1:0]              prod;
  bk_state_t                      state, state_next;

  logic                issue, load;
  logic [CNT_W-1:0]    push_cnt, fresh_cnt, push_m1, fresh_m1;
  status_t             st;
  src_t                src;
  logic                dec_push, inc_push, dec_fresh, mem_re, mem_we;
  logic [MEM_AW-1:0]   raddr, waddr;
  logic [ADDR_BITS+FADDR_W-1:0] faddr_ext, res_ext;

  status_t             res_status;
  logic [CLS_W-1:0]    res_cls;
  src_t                res_src;
  logic [ADDR_BITS-1:0] res_addr;

  assign push_cnt  = pushed[q_entry.cls];
  assign fresh_cnt = fresh[q_entry.cls];
  assign push_m1   = push_cnt - 1'b1;
  assign fresh_m1  = fresh_cnt - 1'b1;
  assign raddr     = {q_entry.cls[CIDX_W-1:0], push_m1[IDX_W-1:0]};
  assign waddr     = {q_entry.cls[CIDX_W-1:0], push_cnt[IDX_W-1:0]};
  assign faddr_ext = {{ADDR_BITS{1'b0}}, q_entry.free_addr};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_ISSUE:  if (issue) state_next = BK_RESULT;
      BK_RESULT: if (load)  state_next = BK_ISSUE;
      default:   state_next = BK_ISSUE;
    endcase
  end

  // Outputs of the issue step
  always_comb begin
    issue     = (state == BK_ISSUE) && q_valid && !base_busy;
    load      = (state == BK_RESULT) && (!m_tvalid || m_tready);
    q_pop     = issue;
    st        = ST_UNSUP;
    src       = SRC_NONE;
    dec_push  = 1'b0;
    inc_push  = 1'b0;
    dec_fresh = 1'b0;
    if (q_entry.found) begin
      if (q_entry.op == OP_ALLOC) begin
        priority if (push_cnt != '0) begin
          st       = ST_OK;
          src      = SRC_STACK;
          dec_push = 1'b1;
        end else if (fresh_cnt != '0) begin
          st        = ST_OK;
          src       = SRC_FRESH;
          dec_fresh = 1'b1;
        end else begin
          st = ST_EMPTY;
        end
      end else if (push_cnt == CNT_W'(MAX_BLOCKS)) begin
        st = ST_FULL;
      end else begin
        st       = ST_OK;
        inc_push = 1'b1;
      end
    end
    mem_re = issue && dec_push;
    mem_we = issue && inc_push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_ISSUE;
    end else begin
      state <= state_next;
    end
  end

  // Counters; a count register write refills its class.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NCLS_MAX; c++) begin
        pushed[c] <= '0;
        fresh[c]  <= CNT_W'(cap_count(RST_COUNT[c], CAP_W'(MAX_BLOCKS)));
      end
    end else if (refill.valid) begin
      pushed[refill.cls] <= '0;
      fresh[refill.cls]  <= CNT_W'(cap_count(refill.count, CAP_W'(MAX_BLOCKS)));
    end else if (issue) begin
      if (dec_push)  pushed[q_entry.cls] <= push_m1;
      if (inc_push)  pushed[q_entry.cls] <= push_cnt + 1'b1;
      if (dec_fresh) fresh[q_entry.cls]  <= fresh_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= faddr_ext[ADDR_BITS-1:0];
    if (mem_re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      res_status <= st;
      res_cls    <= q_entry.cls;
      res_src    <= src;
      if (dec_fresh) prod <= PROD_W'(fresh_m1) * PROD_W'(sizes[q_entry.cls]);
    end
  end

  always_comb begin
    unique case (res_src)
      SRC_STACK: res_addr = rdata;
      SRC_FRESH: res_addr = ADDR_BITS'(bases[res_cls] + ADDR_BITS'(prod));
      default:   res_addr = '0;
    endcase
    res_ext = {{FADDR_W{1'b0}}, res_addr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {2'b00, res_cls, res_ext[FADDR_W-1:0]};
      m_tuser <= {res_status, res_status == ST_OK};
    end
  end

endmodule

### tb/sv/size_class_pool_allocator_unit_tb.sv
// Self-checking testbench of the size-class pool allocator: directed script, random mixes.
module size_class_pool_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scpa_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 6;
  localparam int          NUM_CLASSES  = 4;
  localparam int          MAX_BLOCKS   = 1024;
  localparam int          ITEMS_PER_MIX = 98;
  localparam int          REG_SETTLE   = 2;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          HOLD_AT      = 200;   // results seen before the long sink hold-off
  localparam int          HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  // Register indexes that no register answers to.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_COUNT_LAST + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP  = '1;

  // One allocator outcome, as it leaves the block.
  typedef struct packed {
    logic        ok;
    logic [19:0] addr;
    logic [1:0]  cls;
    status_t     status;
  } outcome_t;

  // Block handed out and not yet given back: freed later with its own size.
  typedef struct packed {
    logic [19:0] addr;
    logic [15:0] size;
  } held_block_t;

  typedef enum logic {
    ROW_REQ,
    ROW_REG
  } row_kind_t;

  // Directed script row: a request (optionally with a typed-in outcome) or a register write.
  typedef struct packed {
    row_kind_t             kind;
    op_t                   op;
    logic [15:0]           size;
    logic [19:0]           addr;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [15:0]           reg_val;
    logic                  fixed;
    outcome_t              want;
  } script_row_t;

  typedef enum int {
    PROF_TIGHT,
    PROF_WIDE,
    PROF_RANDOM
  } pool_profile_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;    // [15:0] req_size, [35:16] free_addr, [39:36] zero
  logic        s_tuser;    // [0] op
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;    // [19:0] block_addr, [21:20] class_index, [23:22] zero
  logic [2:0]  m_tuser;    // [0] ok, [2:1] status
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_data;

  // Predictor state: pool geometry and per-class free lists.
  logic [15:0]  pool_size  [NUM_CLASSES];
  logic [10:0]  pool_count [NUM_CLASSES];
  logic [19:0]  pool_base  [NUM_CLASSES];
  int unsigned  fresh_left [NUM_CLASSES];
  int unsigned  lifo_depth [NUM_CLASSES];
  logic [19:0]  lifo_mem   [NUM_CLASSES][MAX_BLOCKS];

  outcome_t     awaited_outcomes[$];
  held_block_t  held_blocks[$];
  script_row_t  dir_script[$];

  int           errors       = 0;
  int           results_seen = 0;
  bit           sender_burst = 1'b0;
  int unsigned  cycle_count  = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  size_class_pool_allocator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned capped(logic [10:0] n);
    return (n > MAX_BLOCKS) ? MAX_BLOCKS : n;
  endfunction

  // Classes are laid out back to back; the sum wraps with the address width.
  function automatic void recompute_bases();
    logic [19:0] acc;
    int unsigned span;
    acc = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      pool_base[c] = acc;
      span = pool_size[c] * capped(pool_count[c]);
      acc  = acc + span[19:0];
    end
  endfunction

  function automatic void reset_pools();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      pool_size[c]  = RST_SIZE[c];
      pool_count[c] = RST_COUNT[c];
      fresh_left[c] = capped(RST_COUNT[c]);
      lifo_depth[c] = 0;
    end
    recompute_bases();
  endfunction

  // Count writes refill the class; unmapped indexes change nothing.
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    if (idx < CFG_COUNT_FIRST) begin
      pool_size[idx[1:0]] = val;
    end else if (idx <= CFG_COUNT_LAST) begin
      pool_count[idx[1:0]] = val[10:0];
      fresh_left[idx[1:0]] = capped(val[10:0]);
      lifo_depth[idx[1:0]] = 0;
    end else begin
      return;
    end
    recompute_bases();
  endfunction

  // First-fit class choice, then pop/push on that class's free list.
  function automatic outcome_t pool_outcome(op_t op, logic [15:0] sz, logic [19:0] fa);
    outcome_t    r;
    int          hit;
    int unsigned prod;
    r        = '0;
    r.status = ST_UNSUP;
    hit      = -1;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (hit < 0 && sz <= pool_size[c]) hit = c;
    end
    if (hit < 0) return r;
    r.cls = 2'(hit);
    if (op == OP_ALLOC) begin
      if (lifo_depth[hit] > 0) begin
        lifo_depth[hit]--;
        r.addr   = lifo_mem[hit][lifo_depth[hit]];
        r.ok     = 1'b1;
        r.status = ST_OK;
      end else if (fresh_left[hit] > 0) begin
        // fresh blocks leave from the top index down
        fresh_left[hit]--;
        prod     = fresh_left[hit] * pool_size[hit];
        r.addr   = pool_base[hit] + prod[19:0];
        r.ok     = 1'b1;
        r.status = ST_OK;
      end else begin
        r.status = ST_EMPTY;
      end
    end else if (lifo_depth[hit] >= MAX_BLOCKS) begin
      r.status = ST_FULL;
    end else begin
      lifo_mem[hit][lifo_depth[hit]] = fa;
      lifo_depth[hit]++;
      r.ok     = 1'b1;
      r.status = ST_OK;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Script rows
  // ---------------------------------------------------------------------------

  function automatic script_row_t row_req(op_t op, logic [15:0] sz, logic [19:0] fa);
    script_row_t r;
    r      = '0;
    r.kind = ROW_REQ;
    r.op   = op;
    r.size = sz;
    r.addr = fa;
    return r;
  endfunction

  function automatic script_row_t row_chk(op_t op, logic [15:0] sz, logic [19:0] fa,
                                          logic ok, logic [19:0] ba, logic [1:0] cls,
                                          status_t st);
    script_row_t r;
    r             = row_req(op, sz, fa);
    r.fixed       = 1'b1;
    r.want.ok     = ok;
    r.want.addr   = ba;
    r.want.cls    = cls;
    r.want.status = st;
    return r;
  endfunction

  function automatic script_row_t row_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    script_row_t r;
    r         = '0;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Appends one row to the end of the directed script.
  function automatic void add_row(script_row_t r);
    dir_script.insert(dir_script.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones; always back to back in a burst phase.
  function automatic int sender_gap();
    int r;
    if (sender_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int sink_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // One request transaction; the outcome is predicted at the accepting edge.
  task automatic send_req(op_t op, logic [15:0] sz, logic [19:0] fa, logic fixed,
                          outcome_t want);
    int       gap;
    outcome_t got;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, fa, sz};
    do @(posedge clk); while (!s_tready);
    got = pool_outcome(op, sz, fa);
    awaited_outcomes.insert(awaited_outcomes.size(), fixed ? want : got);
    if (op == OP_ALLOC && got.ok) held_blocks.insert(held_blocks.size(), {got.addr, sz});
  endtask

  // Register writes only once every outstanding outcome has come back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_outcomes.size() != 0);
    repeat (REG_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic program_pools(pool_profile_t prof);
    logic [15:0] sz;
    logic [15:0] cnt;
    int          r;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      r = $urandom_range(0, 99);
      case (prof)
        PROF_TIGHT: begin
          sz  = (c == 0) ? 16'd0 : 16'($urandom_range(1, 4 * c));
          cnt = 16'($urandom_range(0, 2));
        end
        PROF_WIDE: begin
          // 0x000f .. 0xffff, with counts mostly at or past the cap: bases wrap
          sz  = 16'hFFFF >> (4 * (NUM_CLASSES - 1 - c));
          cnt = (r < 40) ? 16'hFFFF : (r < 70) ? 16'd1024 : 16'($urandom);
        end
        default: begin
          sz  = (r < 15) ? 16'd0 : (r < 30) ? 16'hFFFF :
                (r < 60) ? 16'($urandom_range(1, 512)) : 16'($urandom);
          r   = $urandom_range(0, 99);
          cnt = (r < 70) ? 16'($urandom_range(0, 30)) : (r < 80) ? 16'd1024 : 16'($urandom);
        end
      endcase
      write_reg(4'(CFG_SIZE_FIRST + c), sz);
      write_reg(4'(CFG_COUNT_FIRST + c), cnt);
    end
    if (prof == PROF_RANDOM && $urandom_range(0, 1) == 1)
      write_reg(4'($urandom_range(CFG_UNMAPPED, CFG_IDX_TOP)), 16'($urandom));
  endtask

  // Mostly well-formed traffic: allocations sized to fit a class, and frees of
  // blocks this run was handed; the rest is noise with random sizes and addresses.
  task automatic run_mix(int n);
    int          r;
    int          c;
    int          k;
    held_block_t b;
    op_t         op;
    logic [15:0] sz;
    logic [19:0] fa;
    held_blocks.delete();
    repeat (n) begin
      r  = $urandom_range(0, 99);
      fa = 20'($urandom);
      if (r < 45) begin
        op = OP_ALLOC;
        c  = $urandom_range(0, NUM_CLASSES - 1);
        sz = 16'($urandom_range(0, pool_size[c]));
      end else if (r < 85 && held_blocks.size() > 0) begin
        k  = $urandom_range(0, held_blocks.size() - 1);
        b  = held_blocks[k];
        held_blocks.delete(k);
        op = OP_FREE;
        sz = b.size;
        fa = b.addr;
      end else begin
        op = op_t'($urandom_range(0, 1));
        sz = 16'($urandom);
      end
      send_req(op, sz, fa, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_ALLOC;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    reset_pools();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset layout: sizes 32/64/128/0, counts 100/50/25/0, bases 0/3200/6400/9600.
    add_row(row_chk(OP_ALLOC, 16'd0, 20'd0, 1'b1, 20'd3168, 2'd0, ST_OK));
    add_row(row_chk(OP_ALLOC, 16'hFFFF, 20'hFFFFF, 1'b0, 20'd0, 2'd0, ST_UNSUP));
    add_row(row_chk(OP_ALLOC, 16'd129, 20'd0, 1'b0, 20'd0, 2'd0, ST_UNSUP));
    add_row(row_chk(OP_ALLOC, 16'd128, 20'd0, 1'b1, 20'd9472, 2'd2, ST_OK));
    add_row(row_chk(OP_FREE, 16'd33, 20'hFFFFF, 1'b1, 20'd0, 2'd1, ST_OK));
    add_row(row_chk(OP_ALLOC, 16'd64, 20'd0, 1'b1, 20'hFFFFF, 2'd1, ST_OK));
    add_row(row_chk(OP_FREE, 16'd1, 20'd0, 1'b1, 20'd0, 2'd0, ST_OK));
    add_row(row_req(OP_ALLOC, 16'd32, 20'h0F0F0));
    // top class opened up with two blocks: drain it, then free and reuse
    add_row(row_reg(CFG_SIZE_FIRST + 4'd3, 16'hFFFF));
    add_row(row_reg(CFG_COUNT_LAST, 16'd2));
    add_row(row_req(OP_ALLOC, 16'hFFFF, 20'd0));
    add_row(row_req(OP_ALLOC, 16'd200, 20'd0));
    add_row(row_chk(OP_ALLOC, 16'hFFFF, 20'd0, 1'b0, 20'd0, 2'd3, ST_EMPTY));
    add_row(row_req(OP_FREE, 16'hFFFF, 20'h5A5A5));
    add_row(row_req(OP_ALLOC, 16'd40000, 20'd0));
    // zero-size class takes only size zero
    add_row(row_reg(CFG_SIZE_FIRST, 16'd0));
    add_row(row_req(OP_ALLOC, 16'd0, 20'd0));
    add_row(row_req(OP_ALLOC, 16'd1, 20'd0));
    // counts: above the cap, empty, exactly at the cap
    add_row(row_reg(CFG_COUNT_FIRST, 16'hFFFF));
    add_row(row_reg(CFG_COUNT_FIRST + 4'd1, 16'd0));
    add_row(row_reg(CFG_COUNT_FIRST + 4'd2, 16'd1024));
    add_row(row_chk(OP_ALLOC, 16'd1, 20'd0, 1'b0, 20'd0, 2'd1, ST_EMPTY));
    add_row(row_req(OP_ALLOC, 16'd100, 20'd0));
    add_row(row_req(OP_ALLOC, 16'd0, 20'd0));
    // unmapped indexes are ignored
    add_row(row_reg(CFG_UNMAPPED, 16'hFFFF));
    add_row(row_reg(CFG_IDX_TOP, 16'h1234));
    add_row(row_req(OP_FREE, 16'd64, 20'h12345));
    add_row(row_req(OP_ALLOC, 16'd64, 20'd0));

    foreach (dir_script[i]) begin
      if (dir_script[i].kind == ROW_REG)
        write_reg(dir_script[i].reg_idx, dir_script[i].reg_val);
      else
        send_req(dir_script[i].op, dir_script[i].size, dir_script[i].addr,
                 dir_script[i].fixed, dir_script[i].want);
    end

    // Random part: several pool layouts, extremes among them.
    for (int ph = 0; ph < 8; ph++) begin
      sender_burst = ($urandom_range(0, 3) == 0);
      case (ph % 4)
        0:       program_pools(PROF_TIGHT);
        2:       program_pools(PROF_WIDE);
        default: program_pools(PROF_RANDOM);
      endcase
      run_mix(ITEMS_PER_MIX);
    end

    s_tvalid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("size_class_pool_allocator_unit_tb: clean");
    else
      $display("size_class_pool_allocator_unit_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure, with one long hold-off while requests
  // keep coming so the queue fills and the input stalls.
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int  run;
    int  stall;
    bit  held;
    held = 1'b0;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && results_seen >= HOLD_AT && s_tvalid) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      run = ($urandom_range(0, 99) < 20) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = sink_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each result transaction against the oldest predicted outcome.
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (awaited_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result with none outstanding, expected nothing got 0x%0h/0x%0h",
                 $time, m_tdata, m_tuser);
      end else begin
        want = awaited_outcomes.pop_front();
        check_field("ok", 20'(want.ok), 20'(m_tuser[0]));
        check_field("block_addr", want.addr, m_tdata[19:0]);
        check_field("class_index", 20'(want.cls), 20'(m_tdata[21:20]));
        check_field("status", 20'(want.status), 20'(m_tuser[2:1]));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("size_class_pool_allocator_unit_tb: errors");
      $finish;
    end
  end

endmodule

### filelist.f
sv/scpa_pkg.sv
sv/scpa_cfg.sv
sv/scpa_front.sv
sv/scpa_queue.sv
sv/scpa_back.sv
sv/size_class_pool_allocator_unit.sv
tb/sv/size_class_pool_allocator_unit_tb.sv
